### hw/rtl/hse_pkg.sv
// shared types and character constants for the html strip and entity decode block
package hse_pkg;

  // characters the decoder looks for or produces
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChR     = 8'h72;

  // raw entity names after the ampersand, first byte in the lowest bits
  localparam int unsigned RawKeep = 5;
  localparam logic [8*RawKeep-1:0] NameLt   = 40'h00_00_3B_74_6C;
  localparam logic [8*RawKeep-1:0] NameGt   = 40'h00_00_3B_74_67;
  localparam logic [8*RawKeep-1:0] NameQuot = 40'h3B_74_6F_75_71;
  localparam logic [8*RawKeep-1:0] NameApos = 40'h3B_73_6F_70_61;
  localparam logic [8*RawKeep-1:0] NameAmp  = 40'h00_3B_70_6D_61;

  // tag check progress
  typedef enum logic [1:0] {
    PFX_IDLE = 2'd0,
    PFX_LT   = 2'd1,
    PFX_LTB  = 2'd2,
    PFX_DONE = 2'd3
  } hse_pfx_t;

  // parser state carried from word to word
  typedef struct packed {
    logic                    in_tag;
    logic                    ent_open;
    hse_pfx_t                pfx;
    logic                    tag_brk;
    logic [8*RawKeep-1:0]    raw;
    logic [2:0]              raw_cnt;
  } hse_state_t;

  // results caused by one input word
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } hse_res_t;

endpackage

### hw/rtl/html_strip_entity_decode.sv
// top level: input register, parser core and result register
//
// channel | dir | tdata            | tlast
// in_     | in  | [7:0] text_byte  | -
// out_    | out | [7:0] out_byte   | last_of_run
//
// one input word per cycle while the result register can take the word's result; the result
// is formed from the input register and registered in the result register before it leaves
// a closing break tag gives two output words, so it holds the result register for both words
// rst_n is synchronous, active low, and clears the parser state and both valid flags
// in_tready stays high while the output stalls until the input register holds a word with a result
module html_strip_entity_decode (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              adv;
  logic              can_load;
  hse_pkg::hse_res_t res;

  // stage advance
  assign adv       = s1_valid_r && (res.cnt == 2'd0 || can_load);
  assign in_tready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  hse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .byte_in (s1_byte_r),
    .res     (res)
  );

  hse_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && res.cnt != 2'd0),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // only a break tag gives two words, and its first one is a carriage return
  a_first_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata == hse_pkg::ChCr)
    else $error("non-final output word is not CR");

  // a carriage return that is not the last word is always followed by the line feed that ends the run
  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tlast && out_tdata == hse_pkg::ChLf)
    else $error("CR not followed by LF");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

### hw/rtl/hse_core.sv
// parser state register and per-word decode logic
module hse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        byte_in,
  output hse_pkg::hse_res_t res
);

  hse_pkg::hse_state_t state_r;
  hse_pkg::hse_state_t state_nxt;
  logic [8*hse_pkg::RawKeep-1:0] raw_app;
  logic [2:0]                    cnt_app;
  logic                          append;

  function automatic logic is_word(input logic [7:0] b);
    is_word = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
              (b >= 8'h41 && b <= 8'h5A) || (b == hse_pkg::ChHash);
  endfunction

  function automatic logic [7:0] decode(input logic [8*hse_pkg::RawKeep-1:0] raw,
                                        input logic [2:0] cnt);
    priority if (cnt == 3'd3 && raw == hse_pkg::NameLt) begin
      decode = hse_pkg::ChLt;
    end else if (cnt == 3'd3 && raw == hse_pkg::NameGt) begin
      decode = hse_pkg::ChGt;
    end else if (cnt == 3'd5 && raw == hse_pkg::NameQuot) begin
      decode = hse_pkg::ChQuot;
    end else if (cnt == 3'd5 && raw == hse_pkg::NameApos) begin
      decode = hse_pkg::ChApos;
    end else if (cnt == 3'd4 && raw == hse_pkg::NameAmp) begin
      decode = hse_pkg::ChAmp;
    end else begin
      decode = hse_pkg::ChQmark;
    end
  endfunction

  // every byte inside an open entity is kept, up to RawKeep bytes, except an ampersand outside a tag
  always_comb begin
    append  = state_r.ent_open && !(byte_in == hse_pkg::ChAmp && !state_r.in_tag);
    raw_app = state_r.raw;
    cnt_app = state_r.raw_cnt;
    if (append && state_r.raw_cnt < 3'(hse_pkg::RawKeep)) begin
      raw_app[{state_r.raw_cnt, 3'b000} +: 8] = byte_in;
      cnt_app = state_r.raw_cnt + 3'd1;
    end
  end

  // next state and results
  always_comb begin
    state_nxt         = state_r;
    state_nxt.raw     = raw_app;
    state_nxt.raw_cnt = cnt_app;
    res               = '0;
    priority if (byte_in == hse_pkg::ChNul) begin
      state_nxt = '0;
    end else if (byte_in == hse_pkg::ChLt) begin
      state_nxt.in_tag  = 1'b1;
      state_nxt.pfx     = hse_pkg::PFX_LT;
      state_nxt.tag_brk = 1'b0;
    end else if (state_r.in_tag) begin
      if (byte_in == hse_pkg::ChGt) begin
        state_nxt.in_tag  = 1'b0;
        state_nxt.pfx     = hse_pkg::PFX_IDLE;
        state_nxt.tag_brk = 1'b0;
        if (state_r.tag_brk) begin
          res.cnt = 2'd2;
          res.b0  = hse_pkg::ChCr;
          res.b1  = hse_pkg::ChLf;
        end
      end else if (state_r.pfx == hse_pkg::PFX_LT) begin
        state_nxt.pfx = (byte_in == hse_pkg::ChB) ? hse_pkg::PFX_LTB : hse_pkg::PFX_DONE;
      end else if (state_r.pfx == hse_pkg::PFX_LTB) begin
        state_nxt.tag_brk = (byte_in == hse_pkg::ChR);
        state_nxt.pfx     = hse_pkg::PFX_DONE;
      end
    end else if (byte_in == hse_pkg::ChAmp) begin
      state_nxt.ent_open = 1'b1;
      state_nxt.raw      = '0;
      state_nxt.raw_cnt  = '0;
    end else if (state_r.ent_open && byte_in == hse_pkg::ChSemi) begin
      res.cnt            = 2'd1;
      res.b0             = decode(raw_app, cnt_app);
      state_nxt.ent_open = 1'b0;
      state_nxt.raw      = '0;
      state_nxt.raw_cnt  = '0;
    end else if (state_r.ent_open && is_word(byte_in)) begin
      // swallowed into the entity
    end else begin
      // plain text, closing any open entity silently
      state_nxt.ent_open = 1'b0;
      state_nxt.raw      = '0;
      state_nxt.raw_cnt  = '0;
      res.cnt            = 2'd1;
      res.b0             = byte_in;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/hse_out.sv
// result register that sends the one or two bytes of each result it loads
module hse_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hse_pkg::hse_res_t res,
  output logic              can_load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic       valid_r;
  logic       two_r;
  logic       phase_r;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic       last_beat;
  logic       pop;

  // beat selection
  assign last_beat  = !two_r || phase_r;
  assign pop        = valid_r && out_tready;
  assign can_load   = !valid_r || (out_tready && last_beat);
  assign out_tvalid = valid_r;
  assign out_tdata  = phase_r ? b1_r : b0_r;
  assign out_tlast  = last_beat;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      two_r   <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      two_r   <= (res.cnt == 2'd2);
      phase_r <= 1'b0;
    end else if (pop) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        phase_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      b0_r <= res.b0;
      b1_r <= res.b1;
    end
  end

endmodule
